// ===== src/tlbprt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbprt_pkg
// Shared widths, command codes and table word layouts of the remap table.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbprt_pkg;

  localparam int unsigned BLK_W       = 8;   // block index bits
  localparam int unsigned PG_W        = 9;   // page index bits within a block
  localparam int unsigned BLOCK_SHIFT = 21;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned ADDR_W      = 29;
  localparam int unsigned PAGE_NUM_W  = 17;
  localparam int unsigned DS_W        = 48;
  localparam int unsigned PHYS_W      = 49;
  localparam int unsigned BLK_CNT     = 1 << BLK_W;
  localparam int unsigned PG_TOTAL    = 1 << (BLK_W + PG_W);

  typedef enum logic [3:0] {
    CMD_XLATE    = 4'd0,
    CMD_SET_BLK  = 4'd1,
    CMD_SET_PG   = 4'd2,
    CMD_SPLIT    = 4'd3,
    CMD_MERGE    = 4'd4,
    CMD_SWAP2    = 4'd5,
    CMD_ROT3     = 4'd6,
    CMD_SWAP_PG  = 4'd7,
    CMD_BUSY_BLK = 4'd8,
    CMD_BUSY_PG  = 4'd9,
    CMD_TRIM_BLK = 4'd10,
    CMD_TRIM_PG  = 4'd11,
    CMD_CHK_BLK  = 4'd12,
    CMD_CHK_PG   = 4'd13
  } cmd_e;

  typedef struct packed {
    logic             busy;
    logic             fine;
    logic [BLK_W-1:0] map;
  } blk_word_t;

  typedef struct packed {
    logic            busy;
    logic [PG_W-1:0] map;
  } pg_word_t;

endpackage

`default_nettype wire

// ===== src/tlbprt_ram.sv =====
// ----------------------------------------------------------------------------
// tlbprt_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbprt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/two_level_block_page_remap_table.sv =====
// ----------------------------------------------------------------------------
// two_level_block_page_remap_table
// Block remap table with optional per-block page maps, one result per command.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one command item; the output
//    channel (out_valid_o/out_ready_i) returns exactly one result item per
//    command: the translation of addr after the command, flags and mismatch.
//  - cfg_we_i/cfg_data_i write data_start; write only while the block is idle.
//  - One item at a time. A sequencer drives two RAMs (block table 256 words,
//    page table 128K words), each with a registered read.
//  - Each item runs as serial RAM steps of the sequencer: block-entry reads
//    (a, b and c for swap/rotate), page-entry reads (a and b for page swap),
//    writes back, then a read of the block entry of addr, and of its page
//    entry when the block has a page map, for the result. Split walks 512
//    page entries, one write a cycle. The next item is taken the cycle after
//    the result is loaded.
//  - Reset: block table reads as identity, coarse and not busy through one
//    valid bit per block entry; no clearing pass. Page entries are written by
//    split before they can be read.
//  - The result sits in an output register; a new item is taken while it
//    waits. If the receiver stalls, the next result holds in the sequencer
//    until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_block_page_remap_table (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tlbprt_pkg::DS_W-1:0]       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [3:0]                        cmd_i,
  input  wire logic [tlbprt_pkg::ADDR_W-1:0]     addr_i,
  input  wire logic [tlbprt_pkg::PG_W-1:0]       value_i,
  input  wire logic [tlbprt_pkg::BLK_W-1:0]      block_a_i,
  input  wire logic [tlbprt_pkg::BLK_W-1:0]      block_b_i,
  input  wire logic [tlbprt_pkg::BLK_W-1:0]      block_c_i,
  input  wire logic [tlbprt_pkg::PAGE_NUM_W-1:0] page_a_i,
  input  wire logic [tlbprt_pkg::PAGE_NUM_W-1:0] page_b_i,
  input  wire logic [tlbprt_pkg::PHYS_W-1:0]     phys_check_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [tlbprt_pkg::PHYS_W-1:0]     phys_addr_o,
  output logic                                   fine_grain_o,
  output logic                                   block_busy_o,
  output logic                                   page_busy_o,
  output logic                                   mismatch_o
);

  import tlbprt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BRD0, S_BRD1, S_BRD2, S_BRD3, S_BWR0, S_BWR1, S_BWR2,
    S_PRD1, S_PRD2, S_PWR1, S_SPLIT, S_FIN0, S_FIN1, S_FIN2, S_CALC_CHK
  } state_e;

  localparam int unsigned PA_W = BLK_W + PG_W;

  // control state
  state_e               state_q, state_d;
  logic [BLK_CNT-1:0]   vld_q, vld_d;        // block entry written since reset
  logic                 blk_rvld_q;
  logic [BLK_W-1:0]     blk_raddr_q;
  logic [DS_W-1:0]      ds_q;
  logic                 out_valid_q, out_valid_d;
  logic [PG_W-1:0]      cnt_q, cnt_d;

  // payload
  logic [3:0]           cmd_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [PG_W-1:0]      value_q;
  logic [BLK_W-1:0]     ba_q, bb_q, bc_q;
  logic [PG_W-1:0]      pa_q, pb_q;
  logic [BLK_W-1:0]     sb_q;
  logic [PHYS_W-1:0]    chk_q;
  blk_word_t            w0_q, w0_d, w1_q, w1_d, w2_q, w2_d, fw_q, fw_d;
  pg_word_t             pw0_q, pw0_d, fpw_q, fpw_d;
  logic [PHYS_W-1:0]    phys_out_q, phys_out_d;
  logic                 fine_out_q, bbusy_out_q, pbusy_out_q, mism_out_q;
  logic                 fine_out_d, bbusy_out_d, pbusy_out_d, mism_out_d;

  // RAM ports
  logic                 blk_we;
  logic [BLK_W-1:0]     blk_waddr, blk_raddr;
  blk_word_t            blk_wdata, blk_raw, blk_rd;
  logic                 pg_we;
  logic [PA_W-1:0]      pg_waddr, pg_raddr;
  pg_word_t             pg_wdata, pg_rd;

  logic [BLK_W-1:0]     blk_b;
  logic [PG_W-1:0]      pg_p;
  logic                 accept;
  logic                 out_free;
  logic [PG_W+PAGE_SHIFT-1:0] off;
  logic [PHYS_W-1:0]    phys_sum, diff;

  assign blk_b    = addr_q[BLOCK_SHIFT +: BLK_W];
  assign pg_p     = addr_q[PAGE_SHIFT +: PG_W];
  assign in_ready_o = (state_q == S_IDLE);
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  tlbprt_ram #(.WIDTH($bits(blk_word_t)), .DEPTH(BLK_CNT)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_raw)
  );

  tlbprt_ram #(.WIDTH($bits(pg_word_t)), .DEPTH(PG_TOTAL)) u_pg_ram (
    .clk_i   (clk_i),
    .we_i    (pg_we),
    .waddr_i (pg_waddr),
    .wdata_i (pg_wdata),
    .raddr_i (pg_raddr),
    .rdata_o (pg_rd)
  );

  // unwritten block entries read as identity, coarse, idle
  always_comb begin
    if (blk_rvld_q) begin
      blk_rd = blk_raw;
    end else begin
      blk_rd = '{busy: 1'b0, fine: 1'b0, map: blk_raddr_q};
    end
  end

  // translation and check arithmetic
  assign off      = fw_q.fine ? {fpw_q.map, addr_q[PAGE_SHIFT-1:0]}
                              : addr_q[BLOCK_SHIFT-1:0];
  assign phys_sum = {1'b0, ds_q} + {{(PHYS_W-BLK_W-BLOCK_SHIFT){1'b0}}, fw_q.map, off};
  assign diff     = chk_q - {1'b0, ds_q};

  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    w0_d = w0_q; w1_d = w1_q; w2_d = w2_q; fw_d = fw_q;
    pw0_d = pw0_q; fpw_d = fpw_q;
    phys_out_d  = phys_out_q;
    fine_out_d  = fine_out_q;
    bbusy_out_d = bbusy_out_q;
    pbusy_out_d = pbusy_out_q;
    mism_out_d  = mism_out_q;
    blk_raddr   = blk_b;
    blk_we      = 1'b0;
    blk_waddr   = blk_b;
    blk_wdata   = w0_q;
    pg_raddr    = {blk_b, pg_p};
    pg_we       = 1'b0;
    pg_waddr    = {blk_b, pg_p};
    pg_wdata    = pw0_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_BRD0;
        end
      end
      S_BRD0: begin
        if (cmd_q == CMD_SWAP2 || cmd_q == CMD_ROT3) begin
          blk_raddr = ba_q;
        end else if (cmd_q == CMD_SWAP_PG) begin
          blk_raddr = sb_q;
        end
        state_d = S_BRD1;
      end
      S_BRD1: begin
        w0_d    = blk_rd;
        state_d = S_FIN0;
        case (cmd_q)
          CMD_SWAP2, CMD_ROT3: begin
            blk_raddr = bb_q;
            state_d   = S_BRD2;
          end
          CMD_SET_BLK: begin
            blk_we    = 1'b1;
            blk_wdata = '{busy: blk_rd.busy, fine: blk_rd.fine, map: value_q[BLK_W-1:0]};
          end
          CMD_SPLIT: begin
            blk_we    = 1'b1;
            blk_wdata = '{busy: blk_rd.busy, fine: 1'b1, map: blk_rd.map};
            cnt_d     = '0;
            state_d   = S_SPLIT;
          end
          CMD_MERGE: begin
            blk_we    = 1'b1;
            blk_wdata = '{busy: blk_rd.busy, fine: 1'b0, map: blk_rd.map};
          end
          CMD_BUSY_BLK, CMD_TRIM_BLK: begin
            blk_we    = 1'b1;
            blk_wdata = '{busy: (cmd_q == CMD_BUSY_BLK), fine: blk_rd.fine,
                          map: blk_rd.map};
          end
          CMD_BUSY_PG: begin
            if (blk_rd.fine) begin
              blk_we    = 1'b1;
              blk_wdata = '{busy: 1'b1, fine: 1'b1, map: blk_rd.map};
              state_d   = S_PRD1;
            end
          end
          CMD_SET_PG, CMD_TRIM_PG: begin
            if (blk_rd.fine) begin
              state_d = S_PRD1;
            end
          end
          CMD_SWAP_PG: begin
            pg_raddr = {sb_q, pa_q};
            if (blk_rd.fine) begin
              state_d = S_PRD1;
            end
          end
          default: begin
          end
        endcase
      end
      S_BRD2: begin
        w1_d      = blk_rd;
        blk_raddr = bc_q;
        state_d   = S_BRD3;
      end
      S_BRD3: begin
        w2_d    = blk_rd;
        state_d = S_BWR0;
      end
      // rotate: a <- b, b <- c, c <- a; flags stay with their entry
      S_BWR0: begin
        blk_we    = 1'b1;
        blk_waddr = ba_q;
        blk_wdata = '{busy: w0_q.busy, fine: w0_q.fine, map: w1_q.map};
        state_d   = S_BWR1;
      end
      S_BWR1: begin
        blk_we    = 1'b1;
        blk_waddr = bb_q;
        blk_wdata = '{busy: w1_q.busy, fine: w1_q.fine, map: w2_q.map};
        state_d   = S_BWR2;
      end
      S_BWR2: begin
        blk_we    = 1'b1;
        blk_waddr = bc_q;
        blk_wdata = '{busy: w2_q.busy, fine: w2_q.fine, map: w0_q.map};
        state_d   = S_FIN0;
      end
      S_PRD1: begin
        pw0_d   = pg_rd;
        state_d = S_FIN0;
        case (cmd_q)
          CMD_SET_PG: begin
            pg_we    = 1'b1;
            pg_wdata = '{busy: pg_rd.busy, map: value_q};
          end
          CMD_BUSY_PG, CMD_TRIM_PG: begin
            pg_we    = 1'b1;
            pg_wdata = '{busy: (cmd_q == CMD_BUSY_PG), map: pg_rd.map};
          end
          CMD_SWAP_PG: begin
            pg_raddr = {sb_q, pb_q};
            state_d  = S_PRD2;
          end
          default: begin
          end
        endcase
      end
      S_PRD2: begin
        pw0_d    = pg_rd;         // now holds entry b
        pg_we    = 1'b1;
        pg_waddr = {sb_q, pa_q};
        pg_wdata = '{busy: pw0_q.busy, map: pg_rd.map};
        fpw_d    = pw0_q;         // keep entry a
        state_d  = S_PWR1;
      end
      S_PWR1: begin
        pg_we    = 1'b1;
        pg_waddr = {sb_q, pb_q};
        pg_wdata = '{busy: pw0_q.busy, map: fpw_q.map};
        state_d  = S_FIN0;
      end
      S_SPLIT: begin
        pg_we    = 1'b1;
        pg_waddr = {blk_b, cnt_q};
        pg_wdata = '{busy: 1'b0, map: cnt_q};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == {PG_W{1'b1}}) begin
          state_d = S_FIN0;
        end
      end
      S_FIN0: begin
        state_d = S_FIN1;
      end
      S_FIN1: begin
        fw_d    = blk_rd;
        state_d = blk_rd.fine ? S_FIN2 : S_CALC_CHK;
      end
      S_FIN2: begin
        fpw_d   = pg_rd;
        state_d = S_CALC_CHK;
      end
      S_CALC_CHK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          phys_out_d  = phys_sum;
          fine_out_d  = fw_q.fine;
          bbusy_out_d = fw_q.busy;
          pbusy_out_d = fw_q.fine && fpw_q.busy;
          case (cmd_q)
            CMD_CHK_BLK: mism_out_d = (chk_q < {1'b0, ds_q}) ||
                           (diff[PHYS_W-1:BLOCK_SHIFT] !=
                            {{(PHYS_W-BLOCK_SHIFT-BLK_W){1'b0}}, fw_q.map});
            CMD_CHK_PG:  mism_out_d = (phys_sum != chk_q);
            default:     mism_out_d = 1'b0;
          endcase
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (blk_we) begin
      vld_d[blk_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      blk_rvld_q  <= 1'b0;
      blk_raddr_q <= '0;
      ds_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      blk_rvld_q  <= vld_q[blk_raddr];
      blk_raddr_q <= blk_raddr;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        ds_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
      value_q <= value_i;
      ba_q    <= block_a_i;
      bb_q    <= block_b_i;
      // a swap is a rotate with the third block equal to the second
      bc_q    <= (cmd_i == CMD_SWAP2) ? block_b_i : block_c_i;
      sb_q    <= page_a_i[PG_W +: BLK_W];
      pa_q    <= page_a_i[PG_W-1:0];
      pb_q    <= page_b_i[PG_W-1:0];
      chk_q   <= phys_check_i;
    end
    w0_q        <= w0_d;
    w1_q        <= w1_d;
    w2_q        <= w2_d;
    fw_q        <= fw_d;
    pw0_q       <= pw0_d;
    fpw_q       <= fpw_d;
    phys_out_q  <= phys_out_d;
    fine_out_q  <= fine_out_d;
    bbusy_out_q <= bbusy_out_d;
    pbusy_out_q <= pbusy_out_d;
    mism_out_q  <= mism_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign phys_addr_o  = phys_out_q;
  assign fine_grain_o = fine_out_q;
  assign block_busy_o = bbusy_out_q;
  assign page_busy_o  = pbusy_out_q;
  assign mismatch_o   = mism_out_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer did not start on accepted item");

  a_split_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPLIT && cnt_q == {PG_W{1'b1}}) |=> state_q == S_FIN0)
    else $error("split walk did not end after last page");

  a_page_write_fine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pg_we && state_q != S_SPLIT) |-> w0_q.fine)
    else $error("page entry written for a coarse block");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC_CHK && out_valid_q && !out_ready_i) |=> state_q == S_CALC_CHK)
    else $error("result left sequencer while output register was full");

endmodule

`default_nettype wire

// ===== tb/sv/two_level_block_page_remap_table_tb.sv =====
// ----------------------------------------------------------------------------
// two_level_block_page_remap_table_tb
// Self-checking bench for the block/page remap table: directed command cases,
// random command streams and a long receiver hold-off, with random idling on
// both channels, checked item by item against a behavioral model of the table in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_block_page_remap_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbprt_pkg::*;

  // Result item as the bench expects it.
  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic              fine;
    logic              bbusy;
    logic              pbusy;
    logic              mism;
  } remap_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [DS_W-1:0]       cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [3:0]            cmd_i = '0;
  logic [ADDR_W-1:0]     addr_i = '0;
  logic [PG_W-1:0]       value_i = '0;
  logic [BLK_W-1:0]      block_a_i = '0;
  logic [BLK_W-1:0]      block_b_i = '0;
  logic [BLK_W-1:0]      block_c_i = '0;
  logic [PAGE_NUM_W-1:0] page_a_i = '0;
  logic [PAGE_NUM_W-1:0] page_b_i = '0;
  logic [PHYS_W-1:0]     phys_check_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PHYS_W-1:0]     phys_addr_o;
  logic                  fine_grain_o;
  logic                  block_busy_o;
  logic                  page_busy_o;
  logic                  mismatch_o;

  two_level_block_page_remap_table DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_o,
    .cmd_i, .addr_i, .value_i, .block_a_i, .block_b_i, .block_c_i,
    .page_a_i, .page_b_i, .phys_check_i, .out_valid_o, .out_ready_i,
    .phys_addr_o, .fine_grain_o, .block_busy_o, .page_busy_o, .mismatch_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model of the table. Page entries are only consulted on split blocks,
  // and split rewrites the whole block first.
  logic [DS_W-1:0]  mdl_start;
  logic [BLK_W-1:0] mdl_blk_map [BLK_CNT];
  logic             mdl_fine [BLK_CNT];
  logic             mdl_bbusy [BLK_CNT];
  logic [PG_W-1:0]  mdl_pg_map [PG_TOTAL];
  logic             mdl_pbusy [PG_TOTAL];

  remap_result_t results_due [$];
  int            n_items, n_results, n_errors, n_splits, n_mism_hits;
  int            idle_cycles;
  bit            hold_off;   // receiver stall forced by the pressure test

  function automatic logic [PHYS_W-1:0] remap_xlate(logic [ADDR_W-1:0] a);
    logic [BLK_W-1:0] b;
    logic [63:0]      r;
    b = a[BLOCK_SHIFT +: BLK_W];
    r = 64'(mdl_start) + (64'(mdl_blk_map[b]) << BLOCK_SHIFT);
    if (mdl_fine[b])
      r += (64'(mdl_pg_map[{b, a[PAGE_SHIFT +: PG_W]}]) << PAGE_SHIFT)
           + 64'(a[PAGE_SHIFT-1:0]);
    else
      r += 64'(a[BLOCK_SHIFT-1:0]);
    return r[PHYS_W-1:0];
  endfunction

  // Applies one command to the model and returns the result it gives.
  function automatic remap_result_t remap_apply(
      cmd_e c, logic [ADDR_W-1:0] a, logic [PG_W-1:0] v,
      logic [BLK_W-1:0] ba, logic [BLK_W-1:0] bb, logic [BLK_W-1:0] bc,
      logic [PAGE_NUM_W-1:0] pa, logic [PAGE_NUM_W-1:0] pb,
      logic [PHYS_W-1:0] chk);
    logic [BLK_W-1:0]      b, t0, t1, t2, sb;
    logic [PG_W-1:0]       p, x;
    logic [BLK_W+PG_W-1:0] s;
    logic                  mm;
    remap_result_t         r;
    b = a[BLOCK_SHIFT +: BLK_W];
    p = a[PAGE_SHIFT +: PG_W];
    s = {b, p};
    mm = 1'b0;
    case (c)
      CMD_SET_BLK: mdl_blk_map[b] = v[BLK_W-1:0];
      CMD_SET_PG:  if (mdl_fine[b]) mdl_pg_map[s] = v;
      CMD_SPLIT: begin
        for (int i = 0; i < (1 << PG_W); i++) begin
          mdl_pg_map[{b, PG_W'(i)}] = PG_W'(i);
          mdl_pbusy[{b, PG_W'(i)}] = 1'b0;
        end
        mdl_fine[b] = 1'b1;
      end
      CMD_MERGE: mdl_fine[b] = 1'b0;
      CMD_SWAP2: begin
        t0 = mdl_blk_map[ba];
        t1 = mdl_blk_map[bb];
        mdl_blk_map[ba] = t1;
        mdl_blk_map[bb] = t0;
      end
      CMD_ROT3: begin
        t0 = mdl_blk_map[ba];
        t1 = mdl_blk_map[bb];
        t2 = mdl_blk_map[bc];
        mdl_blk_map[ba] = t1;
        mdl_blk_map[bb] = t2;
        mdl_blk_map[bc] = t0;
      end
      CMD_SWAP_PG: begin
        sb = pa[PG_W +: BLK_W];
        if (mdl_fine[sb]) begin
          x = mdl_pg_map[{sb, pa[PG_W-1:0]}];
          mdl_pg_map[{sb, pa[PG_W-1:0]}] = mdl_pg_map[{sb, pb[PG_W-1:0]}];
          mdl_pg_map[{sb, pb[PG_W-1:0]}] = x;
        end
      end
      CMD_BUSY_BLK: mdl_bbusy[b] = 1'b1;
      CMD_BUSY_PG: if (mdl_fine[b]) begin
        mdl_bbusy[b] = 1'b1;
        mdl_pbusy[s] = 1'b1;
      end
      CMD_TRIM_BLK: mdl_bbusy[b] = 1'b0;
      CMD_TRIM_PG:  if (mdl_fine[b]) mdl_pbusy[s] = 1'b0;
      CMD_CHK_BLK: begin
        if (chk < PHYS_W'(mdl_start)) mm = 1'b1;
        else mm = ((chk - PHYS_W'(mdl_start)) >> BLOCK_SHIFT) != PHYS_W'(mdl_blk_map[b]);
      end
      CMD_CHK_PG: mm = remap_xlate(a) != chk;
      default: ;
    endcase
    r.phys  = remap_xlate(a);
    r.fine  = mdl_fine[b];
    r.bbusy = mdl_bbusy[b];
    r.pbusy = mdl_fine[b] & mdl_pbusy[s];
    r.mism  = mm;
    return r;
  endfunction

  // Sends one command item; the expectation is queued at acceptance.
  // Valid stays high into the next item when there is no gap.
  task automatic send_cmd(
      logic [3:0] c, logic [ADDR_W-1:0] a, logic [PG_W-1:0] v = '0,
      logic [BLK_W-1:0] ba = '0, logic [BLK_W-1:0] bb = '0,
      logic [BLK_W-1:0] bc = '0, logic [PAGE_NUM_W-1:0] pa = '0,
      logic [PAGE_NUM_W-1:0] pb = '0, logic [PHYS_W-1:0] chk = '0,
      bit no_gap = 1'b0);
    int gap;
    gap = 0;
    if (!no_gap)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
          : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c; addr_i <= a; value_i <= v;
    block_a_i <= ba; block_b_i <= bb; block_c_i <= bc;
    page_a_i <= pa; page_b_i <= pb; phys_check_i <= chk;
    do @(posedge clk_i); while (!in_ready_o);
    results_due.push_back(remap_apply(cmd_e'(c), a, v, ba, bb, bc, pa, pb, chk));
    if (c == CMD_SPLIT) n_splits++;
    n_items++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    remap_result_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = {phys_addr_o, fine_grain_o, block_busy_o, page_busy_o, mismatch_o};
      n_results++;
      if (results_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        want = results_due.pop_front();
        if (want.mism) n_mism_hits++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d: phys %h/%h fine %b/%b bbusy %b/%b pbusy %b/%b mism %b/%b",
                     n_results, want.phys, got.phys, want.fine, got.fine,
                     want.bbusy, got.bbusy, want.pbusy, got.pbusy, want.mism, got.mism);
        end
      end
    end
  end

  // Receiver: random stalls, mostly short; hold_off forces a long one.
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
    else if (!out_ready_i && $urandom_range(0, 9) < 3) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog: ends the run as failed when neither channel moves; its limit covers a split walk and long stalls.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("two_level_block_page_remap_table regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_start(logic [DS_W-1:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_start = d;
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'($urandom());
  endfunction

  // Directed: every command and each corner the command set names.
  task automatic test_directed();
    logic [ADDR_W-1:0] a, z;
    a = {8'd5, 9'd7, 12'hABC};
    z = '1;
    send_cmd(CMD_XLATE, '0);
    send_cmd(CMD_XLATE, z);
    send_cmd(CMD_SET_PG, a, 9'd3);          // page op on coarse block: ignored
    send_cmd(CMD_BUSY_PG, a);
    send_cmd(CMD_SWAP_PG, a, '0, '0, '0, '0, {8'd5, 9'd1}, 17'd2);
    send_cmd(CMD_SET_BLK, a, 9'h1FF);
    send_cmd(CMD_SPLIT, a);
    send_cmd(CMD_SET_PG, a, 9'h1FF);
    send_cmd(CMD_SWAP_PG, a, '0, '0, '0, '0, {8'd5, 9'd7}, {8'd9, 9'd0});
    send_cmd(CMD_BUSY_PG, a);
    send_cmd(CMD_TRIM_PG, a);
    send_cmd(CMD_BUSY_PG, a);
    send_cmd(CMD_SPLIT, a);                 // re-split clears page map and busy
    send_cmd(CMD_BUSY_BLK, z);
    send_cmd(CMD_TRIM_BLK, z);
    send_cmd(CMD_SWAP2, a, '0, 8'd5, 8'd255);
    send_cmd(CMD_ROT3, a, '0, 8'd0, 8'd5, 8'd255);
    send_cmd(CMD_ROT3, a, '0, 8'd5, 8'd5, 8'd0);   // repeated blocks
    send_cmd(CMD_CHK_BLK, a, '0, '0, '0, '0, '0, '0, remap_xlate(a));
    send_cmd(CMD_CHK_BLK, a, '0, '0, '0, '0, '0, '0, '1);
    send_cmd(CMD_CHK_PG, a, '0, '0, '0, '0, '0, '0, remap_xlate(a));
    send_cmd(CMD_CHK_PG, a, '0, '0, '0, '0, '0, '0, '0);
    send_cmd(CMD_MERGE, a);
    send_cmd(CMD_MERGE, a);                 // merge of a coarse block
    send_cmd(4'd14, z);
    send_cmd(4'd15, a);
    wait_idle();
  endtask

  // Random stream over a small set of hot blocks so that page state builds
  // up; splits are rare since each walks the whole page map.
  task automatic test_random(int n);
    logic [3:0]            c;
    logic [ADDR_W-1:0]     a;
    logic [PAGE_NUM_W-1:0] pa;
    logic [PHYS_W-1:0]     chk;
    for (int k = 0; k < n; k++) begin
      a = rand_addr();
      if ($urandom_range(0, 3) != 0)
        a[BLOCK_SHIFT +: BLK_W] = BLK_W'($urandom_range(0, 7) * 37);
      c = 4'($urandom_range(0, 15));
      if (c == CMD_SPLIT && $urandom_range(0, 3) != 0) c = CMD_XLATE;
      pa = PAGE_NUM_W'($urandom());
      if ($urandom_range(0, 1)) pa[PG_W +: BLK_W] = a[BLOCK_SHIFT +: BLK_W];
      case ($urandom_range(0, 3))
        0: chk = remap_xlate(a);
        1: chk = remap_xlate(a) ^ (PHYS_W'(1) << $urandom_range(0, PHYS_W-1));
        2: chk = PHYS_W'({$urandom(), $urandom()});
        default: chk = PHYS_W'(mdl_start) - PHYS_W'($urandom_range(0, 1));
      endcase
      send_cmd(c, a, PG_W'($urandom()), BLK_W'($urandom()), BLK_W'($urandom()),
               BLK_W'($urandom()), pa, PAGE_NUM_W'($urandom()), chk);
    end
    wait_idle();
  endtask

  // Pressure: receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 10; k++) send_cmd(CMD_XLATE, rand_addr(), .no_gap(1'b1));
    join
    wait_idle();
  endtask

  initial begin
    mdl_start = '0;
    for (int i = 0; i < BLK_CNT; i++) begin
      mdl_blk_map[i] = BLK_W'(i);
      mdl_fine[i] = 1'b0;
      mdl_bbusy[i] = 1'b0;
    end
    for (int i = 0; i < PG_TOTAL; i++) begin
      mdl_pg_map[i] = '0;
      mdl_pbusy[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_start('1);                         // top of range: sums carry into the 49th bit
    test_random(200);
    write_start(48'h0000_1234_5000);
    test_backpressure();
    test_random(300);
    write_start(DS_W'($urandom()));
    test_random(300);
    write_start('0);
    test_directed();
    $display("covered %0d items, %0d results, %0d splits, %0d mismatch flags expected",
             n_items, n_results, n_splits, n_mism_hits);
    $display("data_start settings: 0, max, mid, random; long receiver hold-off exercised");
    if (n_errors == 0)
      $display("two_level_block_page_remap_table regression: pass");
    else
      $display("two_level_block_page_remap_table regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

// ===== two_level_block_page_remap_table.f =====
src/tlbprt_pkg.sv
src/tlbprt_ram.sv
src/two_level_block_page_remap_table.sv
tb/sv/two_level_block_page_remap_table_tb.sv
